// ===== hdl/mse_pkg.sv =====
// Shared definitions for the stream-event expander.
// Status codes and fixed field widths; no dependencies.
package mse_pkg;

    // Fixed field widths
    localparam int WORD_W   = 32;
    localparam int CFG_W    = 16;
    localparam int STATUS_W = 3;
    localparam int PLEN_W   = 24;   // parameter byte length field of an event word

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOROOM   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOEVENT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SRCSHORT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DSTSHORT = 3'd4;

endpackage

// ===== hdl/midi_stream_event_expander.sv =====
// Stream-event buffer expander: top level.
// Expands delta/event pairs, inserts stream-id words and copies parameter words.
// Depends on mse_pkg.
//
// Channel   | Dir | tdata (low bit up)                      | tlast    | tuser
// ----------+-----+-----------------------------------------+----------+-----------
// s_        | in  | in_word[31:0], zero pad                 | in_last  | -
// m_        | out | out_word[31:0], bytes_written, zero pad | out_end  | out_status
// cfg_wr_*  | in  | dst_capacity_words[15:0]                | -        | -
//
// A request is held in an input register and expanded into a result register.
// Event and parameter words give one result each, drained words none; a delta word
// with room gives two, itself and a stream-id word, on the single result port.
// aresetn is synchronous, active low; capacity resets to 16384 words.
// Room is reloaded from the capacity register at the first word of each buffer.
// A stalled result port stops expansion; dropped words still drain while stalled.
module midi_stream_event_expander
    import mse_pkg::*;
#(
    parameter int CAPACITY_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_W-1:0]      cfg_wr_data,
    // source words
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [WORD_W-1:0]     s_tdata,    // in_word[31:0]
    input  logic                  s_tlast,    // in_last
    // expanded words
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [((WORD_W+CAPACITY_BITS+2+7)/8)*8-1:0] m_tdata,
                                              // out_word[31:0], bytes_written, zero pad
    output logic                  m_tlast,    // out_end
    output logic [STATUS_W-1:0]   m_tuser     // out_status
);

    localparam int CB     = CAPACITY_BITS;
    localparam int RW     = CAPACITY_BITS + 2;
    localparam int TD_W   = ((WORD_W + RW + 7) / 8) * 8;
    localparam int PAD_W  = TD_W - WORD_W - RW;
    localparam int WCNT_W = PLEN_W - 1;                  // rounded word count width
    localparam int CMP_W  = (CB > WCNT_W) ? CB : WCNT_W;
    localparam int EXT_W  = (CB > CFG_W) ? CB : CFG_W;

    // Phase codes
    localparam logic [1:0] PH_DELTA  = 2'd0;
    localparam logic [1:0] PH_EVENT  = 2'd1;
    localparam logic [1:0] PH_PARAMS = 2'd2;
    localparam logic [1:0] PH_DRAIN  = 2'd3;

    // Configuration register
    logic [CFG_W-1:0] cap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CFG_W'(16384);
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    logic [EXT_W-1:0] cap_ext;
    logic [CB-1:0]    cap_room;
    assign cap_ext  = EXT_W'(cap_reg);
    assign cap_room = cap_ext[CB-1:0];

    // Input holding register
    logic              hold_valid_reg;
    logic [WORD_W-1:0] hold_word_reg;
    logic              hold_last_reg;

    // Expansion state
    logic [1:0]    phase_reg, phase_next;
    logic          sub_reg, sub_next;        // second result of a delta word pending
    logic [CB-1:0] extra_reg, extra_next;
    logic [CB-1:0] room_reg, room_next;
    logic [RW-1:0] written_reg, written_next;

    // Result register
    logic                m_valid_reg;
    logic [WORD_W-1:0]   m_word_reg;
    logic                m_end_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [RW-1:0]       m_bytes_reg;

    // Per-step results
    logic                res_valid;
    logic [WORD_W-1:0]   res_word;
    logic                res_end;
    logic [STATUS_W-1:0] res_status;
    logic [RW-1:0]       res_bytes;
    logic                item_done;
    logic                out_free;
    logic                fire;

    // Helpers
    logic [CB-1:0]     room_eff;
    logic [CB-1:0]     room_dec;
    logic [CB-1:0]     extra_dec;
    logic [RW-1:0]     written_inc;
    logic [WCNT_W-1:0] words;
    logic [CMP_W-1:0]  words_ext;
    logic [CMP_W-1:0]  room_ext;

    assign room_eff    = (phase_reg == PH_DELTA && written_reg == '0) ? cap_room : room_reg;
    assign room_dec    = (room_eff != '0) ? room_eff - CB'(1) : room_eff;
    assign extra_dec   = (extra_reg != '0) ? extra_reg - CB'(1) : extra_reg;
    assign written_inc = written_reg + RW'(4);
    assign words       = hold_word_reg[WORD_W-1]
                         ? WCNT_W'(({1'b0, hold_word_reg[PLEN_W-1:0]} + 25'd3) >> 2)
                         : '0;
    assign words_ext   = CMP_W'(words);
    assign room_ext    = CMP_W'(room_dec);

    // Expansion of the held word
    always_comb begin
        res_valid    = 1'b0;
        res_word     = '0;
        res_end      = 1'b0;
        res_status   = ST_OK;
        res_bytes    = written_reg;
        item_done    = 1'b1;
        phase_next   = phase_reg;
        sub_next     = 1'b0;
        extra_next   = extra_reg;
        room_next    = room_eff;
        written_next = written_reg;

        unique case (phase_reg)
            PH_DRAIN: begin
                if (hold_last_reg) begin
                    phase_next = PH_DELTA;
                end
            end
            PH_DELTA: begin
                res_valid = 1'b1;
                if (sub_reg) begin
                    // inserted stream-id word
                    room_next    = room_dec;
                    written_next = written_inc;
                    res_bytes    = written_inc;
                    res_end      = hold_last_reg;
                    res_status   = hold_last_reg ? ST_NOEVENT : ST_OK;
                    phase_next   = hold_last_reg ? PH_DELTA : PH_EVENT;
                end else if (room_eff < CB'(3)) begin
                    res_end    = 1'b1;
                    res_status = ST_NOROOM;
                    phase_next = hold_last_reg ? PH_DELTA : PH_DRAIN;
                end else begin
                    // delta word itself; the stream-id word follows as the next result
                    room_next    = room_dec;
                    written_next = written_inc;
                    res_bytes    = written_inc;
                    res_word     = hold_word_reg;
                    sub_next     = 1'b1;
                    item_done    = 1'b0;
                end
            end
            PH_EVENT: begin
                res_valid    = 1'b1;
                res_word     = hold_word_reg;
                room_next    = room_dec;
                written_next = written_inc;
                res_bytes    = written_inc;
                priority if (words == '0) begin
                    res_end    = hold_last_reg;
                    phase_next = PH_DELTA;
                end else if (hold_last_reg) begin
                    res_end    = 1'b1;
                    res_status = ST_SRCSHORT;
                    phase_next = PH_DELTA;
                end else if (words_ext > room_ext) begin
                    res_end    = 1'b1;
                    res_status = ST_DSTSHORT;
                    phase_next = PH_DRAIN;
                end else begin
                    extra_next = words_ext[CB-1:0];
                    phase_next = PH_PARAMS;
                end
            end
            PH_PARAMS: begin
                res_valid    = 1'b1;
                res_word     = hold_word_reg;
                room_next    = room_dec;
                written_next = written_inc;
                res_bytes    = written_inc;
                extra_next   = extra_dec;
                priority if (extra_dec == '0) begin
                    res_end    = hold_last_reg;
                    phase_next = hold_last_reg ? PH_DELTA : PH_DELTA;
                end else if (hold_last_reg) begin
                    res_end    = 1'b1;
                    res_status = ST_SRCSHORT;
                    phase_next = PH_DELTA;
                end else begin
                    // more parameter words follow
                    phase_next = PH_PARAMS;
                end
            end
            default: begin
            end
        endcase

        // end of buffer: fresh start for the next word
        if (item_done && hold_last_reg) begin
            phase_next   = PH_DELTA;
            extra_next   = '0;
            room_next    = cap_room;
            written_next = '0;
        end
    end

    // Handshake
    assign out_free = !m_valid_reg || m_tready;
    assign fire     = hold_valid_reg && (out_free || !res_valid);
    assign s_tready = !hold_valid_reg || (fire && item_done);

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (s_tready) begin
            hold_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            hold_word_reg <= s_tdata;
            hold_last_reg <= s_tlast;
        end
    end

    // State update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_DELTA;
            sub_reg     <= 1'b0;
            extra_reg   <= '0;
            room_reg    <= CB'(16384 % (1 << CAPACITY_BITS));
            written_reg <= '0;
        end else if (fire) begin
            phase_reg   <= phase_next;
            sub_reg     <= sub_next;
            extra_reg   <= extra_next;
            room_reg    <= room_next;
            written_reg <= written_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire && res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res_valid) begin
            m_word_reg   <= res_word;
            m_end_reg    <= res_end;
            m_status_reg <= res_status;
            m_bytes_reg  <= res_bytes;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_end_reg;
    assign m_tuser  = m_status_reg;

    generate
        if (PAD_W > 0) begin : g_pad
            assign m_tdata = {{PAD_W{1'b0}}, m_bytes_reg, m_word_reg};
        end else begin : g_nopad
            assign m_tdata = {m_bytes_reg, m_word_reg};
        end
    endgenerate

    // Checks
    a_err_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_status_reg != ST_OK) |-> m_end_reg)
        else $error("error result without end mark");

    a_sub_delta: assert property (@(posedge aclk) disable iff (!aresetn)
        sub_reg |-> (phase_reg == PH_DELTA) && hold_valid_reg)
        else $error("stream-id pending outside delta phase");

    a_extra_params: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PARAMS) == (extra_reg != '0))
        else $error("parameter count out of step with phase");

    a_ok_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_status_reg == ST_OK) |-> (m_bytes_reg != '0))
        else $error("written result with zero byte count");

endmodule
